// File: sv/pfe_pkg.sv
// ----------------------------------------------------------------------------
// pfe_pkg
// Shared types, letter codes and command codes for the Playfair pair
// encryption block.
// ----------------------------------------------------------------------------
package pfe_pkg;

	localparam int EDGE    = 5;
	localparam int CELLS   = 25;
	localparam int LETTERS = 26;

	typedef logic [4:0] letter_t;
	typedef logic [4:0] cell_t;
	typedef logic [2:0] coord_t;

	localparam letter_t LET_I = 5'd8;
	localparam letter_t LET_J = 5'd9;
	localparam letter_t LET_Z = 5'd25;

	localparam logic [1:0] CMD_START  = 2'd0;
	localparam logic [1:0] CMD_LETTER = 2'd1;
	localparam logic [1:0] CMD_FINISH = 2'd2;
	localparam logic [1:0] CMD_CRYPT  = 2'd3;

	localparam logic [1:0] RULE_COL  = 2'd0;
	localparam logic [1:0] RULE_ROW  = 2'd1;
	localparam logic [1:0] RULE_RECT = 2'd2;

	typedef struct packed {
		coord_t row;
		coord_t col;
	} pos_t;

	typedef struct packed {
		cell_t      cell_a;
		cell_t      cell_b;
		logic [1:0] rule;
	} sel_t;

	// Cell index from row and column: row * 5 + col.
	function automatic cell_t cell_of(coord_t row, coord_t col);
		cell_t r5;
		cell_t c5;
		r5 = {2'b00, row};
		c5 = {2'b00, col};
		return (r5 << 2) + r5 + c5;
	endfunction

	// Step one place along a row or column, wrapping at the edge.
	function automatic coord_t wrap_next(coord_t v);
		return (v == coord_t'(EDGE - 1)) ? '0 : v + 3'd1;
	endfunction

endpackage

// File: sv/pfe_ram.sv
// ----------------------------------------------------------------------------
// pfe_ram
// Generic RAM: one write port, two read ports with registered read data.
// ----------------------------------------------------------------------------
module pfe_ram #(
	parameter int WIDTH = 5,
	parameter int DEPTH = 25
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr_a,
	input  logic [$clog2(DEPTH)-1:0] raddr_b,
	output logic [WIDTH-1:0]         rdata_a,
	output logic [WIDTH-1:0]         rdata_b
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata_a <= mem[raddr_a];
			rdata_b <= mem[raddr_b];
		end
	end

endmodule

// File: sv/pfe_lane.sv
// ----------------------------------------------------------------------------
// pfe_lane
// One letter lane: letter normalization ahead of the place lookup, and
// row/column decode of the place that comes back.
// ----------------------------------------------------------------------------
module pfe_lane import pfe_pkg::*; (
	input  logic    [4:0] letter,
	input  logic          pad,
	input  cell_t         place,
	output letter_t       code,
	output pos_t          pos
);

	letter_t sat;

	always_comb begin
		sat  = (letter > LET_Z) ? LET_Z : letter;
		code = pad ? LET_Z : ((sat == LET_J) ? LET_I : sat);
	end

	// Divide by five through a compare chain; places past the square read as zero.
	always_comb begin
		pos.row = '0;
		pos.col = '0;
		if (place < cell_t'(CELLS)) begin
			if (place >= cell_t'(20)) begin
				pos.row = 3'd4;
				pos.col = coord_t'(place - cell_t'(20));
			end else if (place >= cell_t'(15)) begin
				pos.row = 3'd3;
				pos.col = coord_t'(place - cell_t'(15));
			end else if (place >= cell_t'(10)) begin
				pos.row = 3'd2;
				pos.col = coord_t'(place - cell_t'(10));
			end else if (place >= cell_t'(EDGE)) begin
				pos.row = 3'd1;
				pos.col = coord_t'(place - cell_t'(EDGE));
			end else begin
				pos.col = coord_t'(place);
			end
		end
	end

endmodule

// File: sv/pfe_merge.sv
// ----------------------------------------------------------------------------
// pfe_merge
// Combines the two lane positions: picks the rule and the two cells of the
// key square that hold the ciphertext letters.
// ----------------------------------------------------------------------------
module pfe_merge import pfe_pkg::*; (
	input  pos_t pos_a,
	input  pos_t pos_b,
	output sel_t sel
);

	always_comb begin
		if (pos_a.col == pos_b.col) begin
			sel.cell_a = cell_of(wrap_next(pos_a.row), pos_a.col);
			sel.cell_b = cell_of(wrap_next(pos_b.row), pos_b.col);
			sel.rule   = RULE_COL;
		end else if (pos_a.row == pos_b.row) begin
			sel.cell_a = cell_of(pos_a.row, wrap_next(pos_a.col));
			sel.cell_b = cell_of(pos_b.row, wrap_next(pos_b.col));
			sel.rule   = RULE_ROW;
		end else begin
			// swap columns
			sel.cell_a = cell_of(pos_a.row, pos_b.col);
			sel.cell_b = cell_of(pos_b.row, pos_a.col);
			sel.rule   = RULE_RECT;
		end
	end

endmodule

// File: sv/playfair_pair_encrypt.sv
// ----------------------------------------------------------------------------
// playfair_pair_encrypt
// Playfair encryption of letter pairs over a 5x5 key square built in place.
// ----------------------------------------------------------------------------
// Encrypt requests flow one per cycle while the input is not stalled. Each
// passes the letter-place memory lookup in the two letter lanes, then the
// key-square lookup, both with registered read data. Start and key-letter
// requests do not stall the input. A finish request holds the input stalled
// while the fill sequencer walks the alphabet, one letter per cycle through
// the single write port of the key memories. A stalled output stalls the
// whole encrypt pipe and the input with it.
// ----------------------------------------------------------------------------
module playfair_pair_encrypt import pfe_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [1:0] cmd,
	input  logic [4:0] letter_a,
	input  logic [4:0] letter_b,
	input  logic       pad_second,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [4:0] out_a,
	output logic [4:0] out_b,
	output logic [1:0] rule_used,
	output logic       key_error
);

	logic               accept;
	logic               advance;
	logic               crypt_acc;
	letter_t            code_a;
	letter_t            code_b;
	cell_t              place_a;
	cell_t              place_b;
	pos_t               pos_a;
	pos_t               pos_b;
	sel_t               sel;
	letter_t            sq_a;
	letter_t            sq_b;

	logic [LETTERS-1:0] in_square_q;
	cell_t              fill_cnt_q;
	logic               key_ready_q;
	logic               fill_q;
	letter_t            walk_q;

	logic               key_we;
	letter_t            wr_letter;

	logic               v_s1;
	logic               err_s1;
	logic               v_s2;
	logic               err_s2;
	logic [1:0]         rule_s2;

	assign advance   = !v_s2 || !out_stall;
	assign in_stall  = fill_q || !advance;
	assign accept    = in_valid && !in_stall;
	assign crypt_acc = accept && (cmd == CMD_CRYPT);

	pfe_lane u_lane_a (
		.letter (letter_a),
		.pad    (1'b0),
		.place  (place_a),
		.code   (code_a),
		.pos    (pos_a)
	);

	pfe_lane u_lane_b (
		.letter (letter_b),
		.pad    (pad_second),
		.place  (place_b),
		.code   (code_b),
		.pos    (pos_b)
	);

	pfe_merge u_merge (
		.pos_a (pos_a),
		.pos_b (pos_b),
		.sel   (sel)
	);

	// Key letters and the fill walk share one write into both memories.
	always_comb begin
		wr_letter = fill_q ? walk_q : code_a;
		key_we    = 1'b0;
		if (fill_q) begin
			key_we = (walk_q != LET_J) && !in_square_q[walk_q]
			         && (fill_cnt_q < cell_t'(CELLS));
		end else if (accept && (cmd == CMD_LETTER)) begin
			key_we = !in_square_q[code_a] && (fill_cnt_q < cell_t'(CELLS));
		end
	end

	pfe_ram #(.WIDTH(5), .DEPTH(LETTERS)) u_place_ram (
		.clk     (clk),
		.we      (key_we),
		.waddr   (wr_letter),
		.wdata   (fill_cnt_q),
		.re      (advance),
		.raddr_a (code_a),
		.raddr_b (code_b),
		.rdata_a (place_a),
		.rdata_b (place_b)
	);

	pfe_ram #(.WIDTH(5), .DEPTH(CELLS)) u_square_ram (
		.clk     (clk),
		.we      (key_we),
		.waddr   (fill_cnt_q),
		.wdata   (wr_letter),
		.re      (advance),
		.raddr_a (sel.cell_a),
		.raddr_b (sel.cell_b),
		.rdata_a (sq_a),
		.rdata_b (sq_b)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_square_q <= '0;
			fill_cnt_q  <= '0;
			key_ready_q <= 1'b0;
			fill_q      <= 1'b0;
			walk_q      <= '0;
		end else begin
			if (key_we) begin
				in_square_q[wr_letter] <= 1'b1;
				fill_cnt_q             <= fill_cnt_q + 5'd1;
			end
			if (fill_q) begin
				walk_q <= walk_q + 5'd1;
				if (walk_q == LET_Z) begin
					fill_q      <= 1'b0;
					key_ready_q <= 1'b1;
				end
			end else if (accept && (cmd == CMD_START)) begin
				in_square_q <= '0;
				fill_cnt_q  <= '0;
				key_ready_q <= 1'b0;
			end else if (accept && (cmd == CMD_FINISH)) begin
				fill_q <= 1'b1;
				walk_q <= '0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else if (advance) begin
			v_s1 <= crypt_acc;
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			err_s1  <= !key_ready_q;
			err_s2  <= err_s1;
			rule_s2 <= sel.rule;
		end
	end

	assign out_valid = v_s2;
	assign key_error = err_s2;
	assign out_a     = err_s2 ? '0 : sq_a;
	assign out_b     = err_s2 ? '0 : sq_b;
	assign rule_used = err_s2 ? RULE_COL : rule_s2;

	a_fill_stalls: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q |-> in_stall)
		else $error("input taken during key fill");

	a_error_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && key_error) |-> (out_a == '0 && out_b == '0 && rule_used == RULE_COL))
		else $error("error result carries letters");

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_cnt_q <= cell_t'(CELLS))
		else $error("fill count past the square");

	a_ready_from_fill: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(key_ready_q) |-> $past(fill_q))
		else $error("key ready without fill");

endmodule
